FILE: hw/rtl/tcq_pkg.sv
// Package for the two-class age-ordered queue.
// Holds request and status codes, class codes and the structs between
// the top level and the per-class cell chains. No dependencies.
package tcq_pkg;

   localparam int STAMP_BITS = 6;

   localparam logic [7:0] CODE_CLASS_C = 8'd99;
   localparam logic [7:0] CODE_CLASS_D = 8'd100;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQ_ANY = 2'd1,
      REQ_DEQ_C   = 2'd2,
      REQ_DEQ_D   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ENQUEUED  = 3'd0,
      ST_DELIVERED = 3'd1,
      ST_UNKNOWN   = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      CLASS_C = 1'b0,
      CLASS_D = 1'b1
   } class_type;

   typedef struct packed {
      logic push;
      logic pop;
   } chain_ctrl_type;

   typedef struct packed {
      logic                  empty;
      logic                  full;
      logic [STAMP_BITS-1:0] head_stamp;
   } chain_stat_type;

endpackage

FILE: hw/rtl/two_class_age_ordered_queue.sv
// Two-class age-ordered queue: one cell-chain FIFO per class and the
// request decode, age compare and response register. Depends on tcq_pkg,
// tcq_chain and tcq_cell.
//
// Usage. A request on the req_ channel is an enqueue (class code and tag)
// or a dequeue of the oldest item of either class or of one named class.
// Each request yields exactly one response on the rsp_ channel, carrying a
// status, the delivered tag and its class; tag and class are zero unless an
// item was delivered. Code 99 selects class c, code 100 class d, and any
// other code is rejected without touching the queues.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while the receiver takes responses;
// every request reads only the two chain heads or fills one free cell,
// and the whole update of a chain (shift or fill) happens at the accepting edge.
// The response register frees up in the same cycle it is taken, so
// req_ready stays high while rsp_ready is high. When the receiver stalls,
// the response is held and req_ready falls until it is taken.
// Reset clears both fill counts, the arrival stamp and the response valid
// flag; the cell contents are not cleared, as an unused cell is never read.
module two_class_age_ordered_queue #(
   parameter int CLASS_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [7:0]          req_species_code,
   input  logic [TAG_BITS-1:0] req_item_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_out_class
);
   import tcq_pkg::*;

   logic accept;

   chain_ctrl_type        ctrl_c;
   chain_ctrl_type        ctrl_d;
   chain_stat_type        stat_c;
   chain_stat_type        stat_d;
   logic [TAG_BITS-1:0]   head_tag_c;
   logic [TAG_BITS-1:0]   head_tag_d;
   logic [STAMP_BITS-1:0] stamp_diff;

   logic [STAMP_BITS-1:0] stamp_ff;
   logic [STAMP_BITS-1:0] stamp_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic [TAG_BITS-1:0] tag_ff;
   logic [TAG_BITS-1:0] tag_in;
   class_type           class_ff;
   class_type           class_in;

   // The response register can take a new entry when empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Modular age compare: class c is older when the d head's stamp lies in
   // the half circle at or after the c head's stamp.
   assign stamp_diff = stat_d.head_stamp - stat_c.head_stamp;

   always_comb begin
      ctrl_c    = '0;
      ctrl_d    = '0;
      stamp_in  = stamp_ff;
      status_in = ST_EMPTY;
      tag_in    = '0;
      class_in  = CLASS_C;

      case (req_kind_type'(req_type))
         REQ_ENQUEUE: begin
            if (req_species_code == CODE_CLASS_C) begin
               if (stat_c.full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in   = ST_ENQUEUED;
                  ctrl_c.push = 1'b1;
               end
            end else if (req_species_code == CODE_CLASS_D) begin
               if (stat_d.full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in   = ST_ENQUEUED;
                  ctrl_d.push = 1'b1;
               end
            end else begin
               status_in = ST_UNKNOWN;
            end
         end
         REQ_DEQ_C: begin
            ctrl_c.pop = !stat_c.empty;
         end
         REQ_DEQ_D: begin
            ctrl_d.pop = !stat_d.empty;
         end
         REQ_DEQ_ANY: begin
            if (!stat_c.empty && !stat_d.empty) begin
               ctrl_c.pop = !stamp_diff[STAMP_BITS-1];
               ctrl_d.pop = stamp_diff[STAMP_BITS-1];
            end else begin
               ctrl_c.pop = !stat_c.empty;
               ctrl_d.pop = !stat_d.empty;
            end
         end
         default: begin
            status_in = ST_EMPTY;
         end
      endcase

      if (ctrl_c.pop) begin
         status_in = ST_DELIVERED;
         tag_in    = head_tag_c;
         class_in  = CLASS_C;
      end else if (ctrl_d.pop) begin
         status_in = ST_DELIVERED;
         tag_in    = head_tag_d;
         class_in  = CLASS_D;
      end

      if (ctrl_c.push || ctrl_d.push) begin
         stamp_in = stamp_ff + STAMP_BITS'(1);
      end

      // Nothing moves unless the request is actually taken.
      if (!accept) begin
         ctrl_c   = '0;
         ctrl_d   = '0;
         stamp_in = stamp_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         stamp_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         stamp_ff     <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         tag_ff    <= tag_in;
         class_ff  <= class_in;
      end
   end

   tcq_chain #(
      .CLASS_DEPTH(CLASS_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) u_chain_c (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl_c),
      .push_tag  (req_item_tag),
      .push_stamp(stamp_ff),
      .head_tag  (head_tag_c),
      .stat      (stat_c)
   );

   tcq_chain #(
      .CLASS_DEPTH(CLASS_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) u_chain_d (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl_d),
      .push_tag  (req_item_tag),
      .push_stamp(stamp_ff),
      .head_tag  (head_tag_d),
      .stat      (stat_d)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_tag   = tag_ff;
   assign rsp_out_class = class_ff;

endmodule

FILE: hw/rtl/tcq_cell.sv
// One storage cell of a class chain: a tag and an arrival stamp.
// Loads a new entry or takes its neighbour's entry on a shift.
// Depends on tcq_pkg.
module tcq_cell #(
   parameter int TAG_BITS = 16
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           shift,
   input  logic [TAG_BITS-1:0]            load_tag,
   input  logic [tcq_pkg::STAMP_BITS-1:0] load_stamp,
   input  logic [TAG_BITS-1:0]            next_tag,
   input  logic [tcq_pkg::STAMP_BITS-1:0] next_stamp,
   output logic [TAG_BITS-1:0]            tag,
   output logic [tcq_pkg::STAMP_BITS-1:0] stamp
);
   import tcq_pkg::*;

   logic [TAG_BITS-1:0]   tag_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff   <= load_tag;
         stamp_ff <= load_stamp;
      end else if (shift) begin
         tag_ff   <= next_tag;
         stamp_ff <= next_stamp;
      end
   end

   assign tag   = tag_ff;
   assign stamp = stamp_ff;

endmodule

FILE: hw/rtl/tcq_chain.sv
// Queue of one class as a row of tcq_cell instances with the head in cell 0.
// A pop shifts every cell one place towards the head; a push fills the
// first unused cell. Depends on tcq_pkg and tcq_cell.
module tcq_chain #(
   parameter int CLASS_DEPTH = 16,
   parameter int TAG_BITS    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tcq_pkg::chain_ctrl_type        ctrl,
   input  logic [TAG_BITS-1:0]            push_tag,
   input  logic [tcq_pkg::STAMP_BITS-1:0] push_stamp,
   output logic [TAG_BITS-1:0]            head_tag,
   output tcq_pkg::chain_stat_type        stat
);
   import tcq_pkg::*;

   localparam int CW = $clog2(CLASS_DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic [TAG_BITS-1:0]   tag_w   [CLASS_DEPTH+1];
   logic [STAMP_BITS-1:0] stamp_w [CLASS_DEPTH+1];

   assign tag_w[CLASS_DEPTH]   = '0;
   assign stamp_w[CLASS_DEPTH] = '0;

   for (genvar i = 0; i < CLASS_DEPTH; i++) begin : g_cell
      tcq_cell #(
         .TAG_BITS(TAG_BITS)
      ) u_cell (
         .clock     (clock),
         .load      (ctrl.push && (count_ff == CW'(i))),
         .shift     (ctrl.pop),
         .load_tag  (push_tag),
         .load_stamp(push_stamp),
         .next_tag  (tag_w[i+1]),
         .next_stamp(stamp_w[i+1]),
         .tag       (tag_w[i]),
         .stamp     (stamp_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_tag        = tag_w[0];
   assign stat.empty      = (count_ff == '0);
   assign stat.full       = (count_ff == CW'(CLASS_DEPTH));
   assign stat.head_stamp = stamp_w[0];

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the two-class age-ordered queue.
// Holds a scoreboard class with its own model of both class queues and the
// arrival stamps. Depends on tcq_pkg and two_class_age_ordered_queue.
module tb_top;
   import tcq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int TAG_W       = 16;
   localparam int ITEM_COUNT  = 1750;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int STEADY_FROM = 900;
   localparam int STEADY_TO   = 1250;
   localparam int IDLE_PCT    = 36;

   // One response as the block should present it.
   typedef struct {
      status_type       status;
      logic [TAG_W-1:0] tag;
      class_type        owner;
   } response_type;

   // The scoreboard keeps its own copy of both class queues. Every accepted
   // request is run through the model at once and the resulting response is
   // queued; responses from the block are then checked in order.
   class queue_scoreboard;
      logic [TAG_W-1:0]      held_tags   [2][DEPTH];
      logic [STAMP_BITS-1:0] held_stamps [2][DEPTH];
      int unsigned           head_idx [2];
      int unsigned           fill     [2];
      logic [STAMP_BITS-1:0] next_stamp;
      response_type          expected_responses [$];
      int unsigned           accepted;
      int unsigned           checked;
      int unsigned           errors;

      function new();
         for (int q = 0; q < 2; q++) begin
            head_idx[q] = 0;
            fill[q]     = 0;
            for (int i = 0; i < DEPTH; i++) begin
               held_tags[q][i]   = '0;
               held_stamps[q][i] = '0;
            end
         end
         next_stamp = '0;
         accepted   = 0;
         checked    = 0;
         errors     = 0;
      endfunction

      function response_type predict_outcome(req_kind_type kind, logic [7:0] code,
                                             logic [TAG_W-1:0] tag);
         response_type          r;
         int                    pick;
         int                    which;
         int unsigned           slot;
         logic [STAMP_BITS-1:0] age_gap;
         r.status = ST_EMPTY;
         r.tag    = '0;
         r.owner  = CLASS_C;
         pick     = -1;
         case (kind)
            REQ_ENQUEUE: begin
               if (code == CODE_CLASS_C || code == CODE_CLASS_D) begin
                  which = (code == CODE_CLASS_D) ? 1 : 0;
                  if (fill[which] >= DEPTH) begin
                     r.status = ST_FULL;
                  end else begin
                     slot = (head_idx[which] + fill[which]) % DEPTH;
                     held_tags[which][slot]   = tag;
                     held_stamps[which][slot] = next_stamp;
                     next_stamp  = next_stamp + 1'b1;
                     fill[which] = fill[which] + 1;
                     r.status = ST_ENQUEUED;
                  end
               end else begin
                  r.status = ST_UNKNOWN;
               end
            end
            REQ_DEQ_C: begin
               if (fill[0] != 0) pick = 0;
            end
            REQ_DEQ_D: begin
               if (fill[1] != 0) pick = 1;
            end
            default: begin
               // Oldest of either class: the stamp difference is taken
               // modulo the stamp width, and a gap below half the range
               // (zero included) means class c holds the older head.
               if (fill[0] != 0 && fill[1] != 0) begin
                  age_gap = held_stamps[1][head_idx[1]] - held_stamps[0][head_idx[0]];
                  pick = (age_gap < (1 << (STAMP_BITS - 1))) ? 0 : 1;
               end else if (fill[0] != 0) begin
                  pick = 0;
               end else if (fill[1] != 0) begin
                  pick = 1;
               end
            end
         endcase
         if (kind != REQ_ENQUEUE && pick >= 0) begin
            r.status       = ST_DELIVERED;
            r.tag          = held_tags[pick][head_idx[pick]];
            r.owner        = (pick == 1) ? CLASS_D : CLASS_C;
            head_idx[pick] = (head_idx[pick] + 1) % DEPTH;
            fill[pick]     = fill[pick] - 1;
         end
         return r;
      endfunction

      function void note_request(req_kind_type kind, logic [7:0] code,
                                 logic [TAG_W-1:0] tag);
         expected_responses.push_back(predict_outcome(kind, code, tag));
         accepted++;
      endfunction

      function void check_response(logic [2:0] status, logic [TAG_W-1:0] tag,
                                   logic owner);
         response_type want;
         if (expected_responses.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: status %0d tag %h class %0d",
                        status, tag, owner);
            return;
         end
         want = expected_responses.pop_front();
         if (status !== want.status || tag !== want.tag || owner !== want.owner) begin
            errors++;
            if (errors <= 10)
               $display({"response %0d: expected status %0d tag %h class %0d,",
                         " got status %0d tag %h class %0d"},
                        checked, want.status, want.tag, want.owner, status, tag, owner);
         end
         checked++;
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_type = REQ_ENQUEUE;
   logic [7:0]       req_species_code = '0;
   logic [TAG_W-1:0] req_item_tag = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_status;
   logic [TAG_W-1:0] rsp_out_tag;
   logic             rsp_out_class;

   queue_scoreboard  sb = new();

   // Set by the stimulus loop while the sender must offer back to back.
   bit               sender_steady = 1'b0;
   // Share of enqueues in the random mix; changed in phases so that the
   // queues are driven both to full and back to empty.
   int unsigned      enqueue_bias = 50;
   int unsigned      cycle_count = 0;

   always #10 clock = ~clock;

   two_class_age_ordered_queue #(
      .CLASS_DEPTH (DEPTH),
      .TAG_BITS    (TAG_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_species_code (req_species_code),
      .req_item_tag     (req_item_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_class    (rsp_out_class)
   );

   // Offers one request and returns once it has been accepted. Any idle
   // cycles come first, so that valid is never dropped under a pending
   // request. The sampled req_ready is the value from before the edge, as
   // the block only updates it in the nonblocking region.
   task automatic send_request(input req_kind_type kind, input logic [7:0] code,
                               input logic [TAG_W-1:0] tag);
      while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_species_code <= code;
      req_item_tag     <= tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, code, tag);
   endtask

   // Most requests are well formed: an enqueue to one of the two known
   // classes, or one of the dequeues. A small share is pure noise, with
   // every field random, which also brings in rejected class codes.
   task automatic random_request();
      req_kind_type     kind;
      logic [31:0]      word_a;
      logic [31:0]      word_b;
      int unsigned      roll;
      word_a = $urandom;
      word_b = $urandom;
      roll   = $urandom_range(99);
      if (roll < 8) begin
         kind = req_kind_type'(word_b[17:16]);
         send_request(kind, word_b[7:0], word_a[TAG_W-1:0]);
      end else if ($urandom_range(99) < enqueue_bias) begin
         send_request(REQ_ENQUEUE, word_b[20] ? CODE_CLASS_D : CODE_CLASS_C,
                      word_a[TAG_W-1:0]);
      end else begin
         case ($urandom_range(3))
            0, 1:    kind = REQ_DEQ_ANY;
            2:       kind = REQ_DEQ_C;
            default: kind = REQ_DEQ_D;
         endcase
         // The code and tag of a dequeue are ignored, so they are left random.
         send_request(kind, word_b[7:0], word_a[TAG_W-1:0]);
      end
   endtask

   // Receiver: checks every response taken at an edge and then chooses
   // rsp_ready for the next cycle. Once, part way through, it holds off for
   // a long stretch while the sender keeps offering, so that the held
   // response backs up into req_ready.
   initial begin : receiver
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_status, rsp_out_tag, rsp_out_class);
         if (!hold_done && sb.accepted >= 400) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (sb.accepted >= STEADY_FROM && sb.accepted < STEADY_TO) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Guards against a hung handshake: when the count runs out the run is
   // failed outright.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Every kind of dequeue on an empty block comes first,
      // then rejected codes either side of the two known ones and at the
      // ends of the byte range.
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      send_request(REQ_DEQ_C,   8'hFF, '1);
      send_request(REQ_DEQ_D,   8'h00, '0);
      send_request(REQ_ENQUEUE, 8'd0,   16'h1234);
      send_request(REQ_ENQUEUE, 8'd255, 16'h4321);
      send_request(REQ_ENQUEUE, 8'd98,  16'h0F0F);
      send_request(REQ_ENQUEUE, 8'd101, 16'hF0F0);
      // Extreme tags in both classes, then the older-first choice between
      // the two heads and a dequeue any with only one class holding items.
      send_request(REQ_ENQUEUE, CODE_CLASS_C, 16'hFFFF);
      send_request(REQ_ENQUEUE, CODE_CLASS_D, 16'h0000);
      send_request(REQ_ENQUEUE, CODE_CLASS_D, 16'hAAAA);
      send_request(REQ_ENQUEUE, CODE_CLASS_C, 16'h5555);
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      send_request(REQ_DEQ_D,   8'h00, '0);
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      // Class dequeues that find their own class empty while the other
      // class still holds an item.
      send_request(REQ_ENQUEUE, CODE_CLASS_D, 16'h8001);
      send_request(REQ_DEQ_C,   8'h00, '0);
      send_request(REQ_DEQ_ANY, 8'h00, '0);
      send_request(REQ_ENQUEUE, CODE_CLASS_C, 16'h7FFE);
      send_request(REQ_DEQ_D,   8'h00, '0);
      send_request(REQ_DEQ_C,   8'h00, '0);

      // Random part. The enqueue share is drawn anew every 64 requests, so the
      // queues fill (and refuse further items) and drain again many times,
      // and the arrival stamp wraps over and over.
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(2))
               0:       enqueue_bias = 85;
               1:       enqueue_bias = 50;
               default: enqueue_bias = 15;
            endcase
         end
         sender_steady = (n >= STEADY_FROM && n < STEADY_TO);
         random_request();
      end
      sender_steady = 1'b0;
      req_valid <= 1'b0;

      // Every request has been accepted: wait for the last responses, then
      // keep watching in case the block sends anything it should not.
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
